[hw/rtl/asn1ts_pkg.sv]
package asn1ts_pkg;

  localparam logic [4:0] TAG_UTC       = 5'd23;
  localparam logic [4:0] TAG_GEN       = 5'd24;
  localparam logic [4:0] LEN_UTC       = 5'd13;
  localparam logic [4:0] LEN_GEN       = 5'd15;
  localparam logic [4:0] YEAR_LEN_UTC  = 5'd2;
  localparam logic [4:0] YEAR_LEN_GEN  = 5'd4;
  localparam logic [4:0] COUNT_MAX     = 5'd31;
  localparam logic [7:0] CHAR_Z        = 8'h5A;
  localparam logic [7:0] DIGIT_LO      = 8'h30;
  localparam logic [7:0] DIGIT_HI      = 8'h39;
  localparam logic [13:0] CENTURY_SPLIT = 14'd50;
  localparam logic [13:0] CENTURY_19    = 14'd1900;
  localparam logic [13:0] CENTURY_20    = 14'd2000;
  localparam int unsigned NUM_FIELDS    = 5;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_LENGTH = 2'd1,
    ST_CHAR   = 2'd2,
    ST_TAG    = 2'd3
  } status_t;

  typedef struct packed {
    logic [4:0] time_tag;
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_item_t;

  typedef struct packed {
    status_t    status;
    logic [13:0] year;
    logic [6:0] month;
    logic [6:0] day;
    logic [6:0] hour_value;
    logic [6:0] minute_value;
    logic [6:0] second_value;
  } time_result_t;

  typedef struct packed {
    logic [4:0]                  byte_count;
    logic [4:0]                  latched_tag;
    logic                        bad_char_seen;
    logic                        final_was_z;
    logic [13:0]                 year_accum;
    logic [NUM_FIELDS-1:0][6:0]  two_digit_accums;
  } parse_state_t;

endpackage

[hw/rtl/asn1ts_byte_step.sv]
module asn1ts_byte_step (
  input  asn1ts_pkg::parse_state_t cur,
  input  asn1ts_pkg::byte_item_t   item,
  output asn1ts_pkg::parse_state_t nxt,
  output asn1ts_pkg::time_result_t result
);

  logic [4:0]  tag;
  logic        known;
  logic        is_gen;
  logic [4:0]  year_len;
  logic [4:0]  full_len;
  logic        is_digit;
  logic [3:0]  digit_val;
  logic        in_digits;
  logic [4:0]  field_off;
  logic [2:0]  field_idx;
  logic [4:0]  count_inc;
  logic [13:0] year_out;
  asn1ts_pkg::parse_state_t upd;
  asn1ts_pkg::status_t      status;

  always_comb begin
    tag       = (cur.byte_count == 5'd0) ? item.time_tag : cur.latched_tag;
    is_gen    = (tag == asn1ts_pkg::TAG_GEN);
    known     = (tag == asn1ts_pkg::TAG_UTC) || is_gen;
    year_len  = is_gen ? asn1ts_pkg::YEAR_LEN_GEN : asn1ts_pkg::YEAR_LEN_UTC;
    full_len  = is_gen ? asn1ts_pkg::LEN_GEN : asn1ts_pkg::LEN_UTC;
    is_digit  = (item.data_byte >= asn1ts_pkg::DIGIT_LO) &&
                (item.data_byte <= asn1ts_pkg::DIGIT_HI);
    // for an ascii digit the value is the low nibble
    digit_val = item.data_byte[3:0];
    in_digits = known && (cur.byte_count < (full_len - 5'd1));
    field_off = cur.byte_count - year_len;
    field_idx = field_off[3:1];
    count_inc = (cur.byte_count != asn1ts_pkg::COUNT_MAX) ?
                (cur.byte_count + 5'd1) : cur.byte_count;

    upd             = cur;
    upd.latched_tag = tag;
    upd.byte_count  = count_inc;
    upd.final_was_z = (item.data_byte == asn1ts_pkg::CHAR_Z);
    if (in_digits) begin
      if (!is_digit) begin
        upd.bad_char_seen = 1'b1;
      end else if (cur.byte_count < year_len) begin
        upd.year_accum = (cur.year_accum << 3) + (cur.year_accum << 1) +
                         {10'd0, digit_val};
      end else begin
        for (int k = 0; k < asn1ts_pkg::NUM_FIELDS; k++) begin
          if (!field_off[4] && (field_idx == 3'(k))) begin
            upd.two_digit_accums[k] = (cur.two_digit_accums[k] << 3) +
                                      (cur.two_digit_accums[k] << 1) +
                                      {3'd0, digit_val};
          end
        end
      end
    end

    priority if (!known) begin
      status = asn1ts_pkg::ST_TAG;
    end else if (upd.byte_count != full_len) begin
      status = asn1ts_pkg::ST_LENGTH;
    end else if (upd.bad_char_seen || !upd.final_was_z) begin
      status = asn1ts_pkg::ST_CHAR;
    end else begin
      status = asn1ts_pkg::ST_OK;
    end

    year_out = upd.year_accum;
    if (tag == asn1ts_pkg::TAG_UTC) begin
      year_out = upd.year_accum + ((upd.year_accum >= asn1ts_pkg::CENTURY_SPLIT) ?
                 asn1ts_pkg::CENTURY_19 : asn1ts_pkg::CENTURY_20);
    end

    result = '0;
    result.status = status;
    if (status == asn1ts_pkg::ST_OK) begin
      result.year         = year_out;
      result.month        = upd.two_digit_accums[0];
      result.day          = upd.two_digit_accums[1];
      result.hour_value   = upd.two_digit_accums[2];
      result.minute_value = upd.two_digit_accums[3];
      result.second_value = upd.two_digit_accums[4];
    end

    // end of string returns all per-string state to reset
    nxt = item.last_byte ? '0 : upd;
  end

endmodule

[hw/rtl/asn1_time_string_parser.sv]
// channel | direction | handshake                | payload
// byte    | in        | byte_valid / byte_ready  | byte_data : asn1ts_pkg::byte_item_t
// time    | out       | time_valid / time_ready  | time_data : asn1ts_pkg::time_result_t
//
// one byte per cycle while byte_ready is high; the digit check and multiply-by-ten
// update of the parse state registers are combinational
// the result of a final byte is in the output register in the cycle after the byte is accepted
// rst (synchronous) clears the parse state and empties the output register
// byte_ready drops only while a result waits in the output register and
// time_ready is low
module asn1_time_string_parser (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     byte_valid,
  output logic                     byte_ready,
  input  asn1ts_pkg::byte_item_t   byte_data,
  output logic                     time_valid,
  input  logic                     time_ready,
  output asn1ts_pkg::time_result_t time_data
);

  asn1ts_pkg::parse_state_t state;
  asn1ts_pkg::parse_state_t state_next;
  asn1ts_pkg::time_result_t result_next;
  logic                     byte_xfer;

  assign byte_ready = !time_valid || time_ready;
  assign byte_xfer  = byte_valid && byte_ready;

  asn1ts_byte_step u_step (
    .cur    (state),
    .item   (byte_data),
    .nxt    (state_next),
    .result (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (byte_xfer) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_valid <= 1'b0;
    end else if (byte_xfer && byte_data.last_byte) begin
      time_valid <= 1'b1;
    end else if (time_ready) begin
      time_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_xfer && byte_data.last_byte) begin
      time_data <= result_next;
    end
  end

endmodule

[hw/rtl/asn1ts_checker.sv]
module asn1ts_checker (
  input logic                     clk,
  input logic                     rst,
  input logic                     byte_valid,
  input logic                     byte_ready,
  input asn1ts_pkg::byte_item_t   byte_data,
  input logic                     time_valid,
  input logic                     time_ready,
  input asn1ts_pkg::time_result_t time_data
);

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    time_valid && !time_ready |=> time_valid && $stable(time_data))
    else $error("result changed while stalled");

  // an empty output register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !time_valid |-> byte_ready)
    else $error("input stalled with empty output");

  // a final byte gives a result in the next cycle
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    byte_valid && byte_ready && byte_data.last_byte |=> time_valid)
    else $error("no result after final byte");

  // error results carry zero fields
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    time_valid && (time_data.status != asn1ts_pkg::ST_OK) |->
      (time_data.year == 14'd0) && (time_data.month == 7'd0) &&
      (time_data.day == 7'd0) && (time_data.hour_value == 7'd0) &&
      (time_data.minute_value == 7'd0) && (time_data.second_value == 7'd0))
    else $error("nonzero fields on error result");

  // two decimal digits per field, four per year
  a_ok_ranges: assert property (@(posedge clk) disable iff (rst)
    time_valid && (time_data.status == asn1ts_pkg::ST_OK) |->
      (time_data.year <= 14'd9999) && (time_data.month <= 7'd99) &&
      (time_data.day <= 7'd99) && (time_data.hour_value <= 7'd99) &&
      (time_data.minute_value <= 7'd99) && (time_data.second_value <= 7'd99))
    else $error("field out of decimal range");

endmodule

bind asn1_time_string_parser asn1ts_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .byte_valid (byte_valid),
  .byte_ready (byte_ready),
  .byte_data  (byte_data),
  .time_valid (time_valid),
  .time_ready (time_ready),
  .time_data  (time_data)
);
